### rtl/hmtb_pkg.sv
// Shared constants and types for the Huffman minimum-code table builder.
package hmtb_pkg;

   // Code lengths per table (JPEG uses 16)
   localparam int CODE_LENGTHS_DEF = 16;

   // Field widths
   localparam int CODE_W  = 16;
   localparam int COUNT_W = 8;
   localparam int RUN_W   = 12;

   // Saturation limits
   localparam logic [RUN_W-1:0]   RUN_MAX = {RUN_W{1'b1}};
   localparam logic [COUNT_W-1:0] CUM_MAX = {COUNT_W{1'b1}};

   // One result word
   typedef struct packed {
      logic [CODE_W-1:0]  min_code;
      logic [COUNT_W-1:0] cum_count;
      logic               count_overflow;
      logic               table_last;
      logic [CODE_W-1:0]  slot0_code;
   } result_type;

endpackage

### rtl/huffman_mincode_table_builder_core.sv
// Top level of the JPEG Huffman minimum-code table builder.
//
// Takes one per-length code count per word, lengths 1 to 16 in order, and
// returns one result word per count: the minimum code of that length, the
// saturated cumulative count with its overflow flag, and on the sixteenth
// length the table_last flag and the slot 0 replacement code. A table start
// flag restarts the table; without it the next table begins on its own after
// the sixteenth length. A count is held in the input register, worked on
// there and loaded into the output register once that register is free;
// one word per cycle is sustained while the result side keeps taking
// words. The rate is set by the per-word update of the running code,
// count and length index. No clearing pass is needed after reset.
module huffman_mincode_table_builder_core #(
   parameter int CODE_LENGTHS = hmtb_pkg::CODE_LENGTHS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [hmtb_pkg::COUNT_W-1:0] req_code_count,
   input  logic                         req_table_start,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hmtb_pkg::CODE_W-1:0]  rsp_min_code,
   output logic [hmtb_pkg::COUNT_W-1:0] rsp_cum_count,
   output logic                         rsp_count_overflow,
   output logic                         rsp_table_last,
   output logic [hmtb_pkg::CODE_W-1:0]  rsp_slot0_code
);
   import hmtb_pkg::*;

   logic               in_valid_ff;
   logic [COUNT_W-1:0] in_count_ff;
   logic               in_start_ff;
   logic               rsp_valid_ff;
   result_type         rsp_word_ff;
   result_type         step_result;
   logic               advance;

   // Move the held input word to the output register when it is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_count_ff <= req_code_count;
         in_start_ff <= req_table_start;
      end
   end

   hmtb_datapath #(
      .CODE_LENGTHS (CODE_LENGTHS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .code_count  (in_count_ff),
      .table_start (in_start_ff),
      .result      (step_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_min_code       = rsp_word_ff.min_code;
   assign rsp_cum_count      = rsp_word_ff.cum_count;
   assign rsp_count_overflow = rsp_word_ff.count_overflow;
   assign rsp_table_last     = rsp_word_ff.table_last;
   assign rsp_slot0_code     = rsp_word_ff.slot0_code;

   // Checks
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while both registers are full");

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count_overflow) |-> (rsp_cum_count == CUM_MAX))
      else $error("overflow flagged without saturated count");

   a_slot0_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_table_last) |-> (rsp_slot0_code == '0))
      else $error("slot 0 code given on a length other than the last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

endmodule

### rtl/hmtb_datapath.sv
// Table-build state and per-length minimum code arithmetic.
module hmtb_datapath #(
   parameter int CODE_LENGTHS = hmtb_pkg::CODE_LENGTHS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  logic [hmtb_pkg::COUNT_W-1:0] code_count,
   input  logic                         table_start,
   output hmtb_pkg::result_type         result
);
   import hmtb_pkg::*;

   localparam int LEN_W = $clog2(CODE_LENGTHS);
   localparam logic [LEN_W-1:0] LAST_IDX = LEN_W'(CODE_LENGTHS - 1);

   logic [CODE_W-1:0] running_code_ff, running_code_in;
   logic [RUN_W-1:0]  running_count_ff, running_count_in;
   logic [CODE_W-1:0] prev_min_code_ff, prev_min_code_in;
   logic [LEN_W-1:0]  length_index_ff, length_index_in;

   logic [LEN_W-1:0]  idx_eff;
   logic [CODE_W-1:0] code_eff;
   logic [RUN_W-1:0]  runc_eff;
   logic [CODE_W:0]   shifted;
   logic              empty_len;
   logic [CODE_W-1:0] min_code;
   logic [CODE_W-1:0] code_sum;
   logic [RUN_W:0]    cnt_sum;
   logic [RUN_W-1:0]  cnt_sat;
   logic              last;
   logic              overflow;

   // Table start clears the running values before this length is handled
   assign idx_eff  = table_start ? '0 : length_index_ff;
   assign code_eff = table_start ? '0 : running_code_ff;
   assign runc_eff = table_start ? '0 : running_count_ff;

   // Minimum code: empty lengths past the first take max(code, prev << 1)
   assign shifted   = {prev_min_code_ff, 1'b0};
   assign empty_len = (code_count == '0) && (idx_eff != '0);

   always_comb begin
      if (empty_len) begin
         if ({1'b0, code_eff} > shifted) begin
            min_code = code_eff;
         end else begin
            min_code = shifted[CODE_W-1:0];
         end
      end else begin
         min_code = code_eff;
      end
   end

   // Running code and saturating cumulative count
   assign code_sum = code_eff + CODE_W'(code_count);
   assign cnt_sum  = {1'b0, runc_eff} + (RUN_W + 1)'(code_count);
   assign cnt_sat  = (cnt_sum > {1'b0, RUN_MAX}) ? RUN_MAX : cnt_sum[RUN_W-1:0];
   assign last     = (idx_eff == LAST_IDX);
   assign overflow = (cnt_sat > RUN_W'(CUM_MAX));

   // Result word
   always_comb begin
      result.min_code       = min_code;
      result.cum_count      = overflow ? CUM_MAX : cnt_sat[COUNT_W-1:0];
      result.count_overflow = overflow;
      result.table_last     = last;
      if (!last) begin
         result.slot0_code = '0;
      end else if (code_count != '0) begin
         result.slot0_code = min_code + CODE_W'(code_count) - CODE_W'(1);
      end else begin
         result.slot0_code = min_code;
      end
   end

   // Next state; the last length wraps back to a fresh table
   always_comb begin
      prev_min_code_in = min_code;
      if (last) begin
         running_code_in  = '0;
         running_count_in = '0;
         length_index_in  = '0;
      end else begin
         running_code_in  = {code_sum[CODE_W-2:0], 1'b0};
         running_count_in = cnt_sat;
         length_index_in  = idx_eff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_code_ff  <= '0;
         running_count_ff <= '0;
         prev_min_code_ff <= '0;
         length_index_ff  <= '0;
      end else if (step_en) begin
         running_code_ff  <= running_code_in;
         running_count_ff <= running_count_in;
         prev_min_code_ff <= prev_min_code_in;
         length_index_ff  <= length_index_in;
      end
   end

endmodule

### tb/sv/huffman_mincode_table_builder_checker.sv
// Result checker for the Huffman minimum-code table builder: predicts each result word and compares.
`timescale 1ns / 100ps

module huffman_mincode_table_builder_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [hmtb_pkg::COUNT_W-1:0] req_code_count,
   input  logic                         req_table_start,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [hmtb_pkg::CODE_W-1:0]  rsp_min_code,
   input  logic [hmtb_pkg::COUNT_W-1:0] rsp_cum_count,
   input  logic                         rsp_count_overflow,
   input  logic                         rsp_table_last,
   input  logic [hmtb_pkg::CODE_W-1:0]  rsp_slot0_code,
   output int                           fail_count,
   output int                           pending_words
);
   import hmtb_pkg::*;

   // Predicted table-builder state
   logic [CODE_W-1:0] next_code;
   logic [RUN_W-1:0]  codes_seen;
   logic [CODE_W-1:0] last_min_code;
   logic [3:0]        length_pos;

   result_type expected_words[$];
   int         errors = 0;

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
   endtask

   task automatic compare_field(input string name, input logic [CODE_W-1:0] got,
                                input logic [CODE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   // Work out the result word for one code-length count and queue it
   task automatic predict_table_entry(input logic [COUNT_W-1:0] count, input logic start);
      logic [CODE_W:0] doubled_prev;
      logic [CODE_W:0] code_sum;
      logic [RUN_W:0]  count_sum;
      result_type      word;
      word = '0;
      if (start) begin
         next_code  = '0;
         codes_seen = '0;
         length_pos = '0;
      end
      // empty length after the first: larger of running code and doubled previous minimum
      doubled_prev = {last_min_code, 1'b0};
      if (count == '0 && length_pos != '0) begin
         word.min_code = ({1'b0, next_code} > doubled_prev) ? next_code
                                                             : doubled_prev[CODE_W-1:0];
      end else begin
         word.min_code = next_code;
      end
      // running code wraps at 16 bits, cumulative count saturates
      code_sum   = {1'b0, next_code} + (CODE_W + 1)'(count);
      next_code  = {code_sum[CODE_W-2:0], 1'b0};
      count_sum  = {1'b0, codes_seen} + (RUN_W + 1)'(count);
      codes_seen = (count_sum > {1'b0, RUN_MAX}) ? RUN_MAX : count_sum[RUN_W-1:0];
      last_min_code = word.min_code;

      word.count_overflow = (codes_seen > RUN_W'(CUM_MAX));
      word.cum_count      = word.count_overflow ? CUM_MAX : codes_seen[COUNT_W-1:0];
      word.table_last     = (int'(length_pos) >= CODE_LENGTHS_DEF - 1);
      if (word.table_last) begin
         word.slot0_code = (count != '0) ? word.min_code + CODE_W'(count) - CODE_W'(1)
                                         : word.min_code;
         next_code  = '0;
         codes_seen = '0;
         length_pos = '0;
      end else begin
         length_pos = length_pos + 4'd1;
      end
      expected_words.push_back(word);
   endtask

   // Watch both channels at each edge
   always @(posedge clock) begin : watch_channels
      result_type want;
      if (reset) begin
         next_code     = '0;
         codes_seen    = '0;
         last_min_code = '0;
         length_pos    = '0;
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected, min_code %h",
                                         rsp_min_code));
            end else begin
               want = expected_words.pop_front();
               compare_field("min_code", rsp_min_code, want.min_code);
               compare_field("cum_count", CODE_W'(rsp_cum_count), CODE_W'(want.cum_count));
               compare_field("count_overflow", CODE_W'(rsp_count_overflow),
                             CODE_W'(want.count_overflow));
               compare_field("table_last", CODE_W'(rsp_table_last),
                             CODE_W'(want.table_last));
               compare_field("slot0_code", rsp_slot0_code, want.slot0_code);
            end
         end
         if (req_valid && req_ready)
            predict_table_entry(req_code_count, req_table_start);
      end
      pending_words <= expected_words.size();
      fail_count    <= errors;
   end

endmodule

### tb/sv/huffman_mincode_table_builder_core_tb.sv
// Testbench top for the Huffman minimum-code table builder: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps

module huffman_mincode_table_builder_core_tb;
   import hmtb_pkg::*;

   localparam int RANDOM_ITEMS  = 1200;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int DIRECTED_LEN  = 25;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [COUNT_W-1:0] req_code_count = '0;
   logic               req_table_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CODE_W-1:0]  rsp_min_code;
   logic [COUNT_W-1:0] rsp_cum_count;
   logic               rsp_count_overflow;
   logic               rsp_table_last;
   logic [CODE_W-1:0]  rsp_slot0_code;

   int fail_count;
   int pending_words;
   int idle_cycles = 0;
   bit quiet = 1'b0;   // no idling on either side while set

   // Directed part: a table without a start after reset, a table that follows on its own,
   // then a start in the middle of it. Saturation and running-code wrap come from the 255s.
   int directed_counts [DIRECTED_LEN] = '{0, 1, 0, 0, 3, 255, 0, 255, 0, 0, 7, 0, 0, 0, 0, 1,
                                          255, 0, 0, 128, 1,
                                          0, 0, 0, 170};
   bit directed_starts [DIRECTED_LEN] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                          0, 0, 0, 0, 0,
                                          1, 0, 0, 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   huffman_mincode_table_builder_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_code_count     (req_code_count),
      .req_table_start    (req_table_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_min_code       (rsp_min_code),
      .rsp_cum_count      (rsp_cum_count),
      .rsp_count_overflow (rsp_count_overflow),
      .rsp_table_last     (rsp_table_last),
      .rsp_slot0_code     (rsp_slot0_code)
   );

   huffman_mincode_table_builder_checker u_result_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_code_count     (req_code_count),
      .req_table_start    (req_table_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_min_code       (rsp_min_code),
      .rsp_cum_count      (rsp_cum_count),
      .rsp_count_overflow (rsp_count_overflow),
      .rsp_table_last     (rsp_table_last),
      .rsp_slot0_code     (rsp_slot0_code),
      .fail_count         (fail_count),
      .pending_words      (pending_words)
   );

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Counts biased towards empty and small lengths so tables stay realistic
   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return '0;
      if (r < 80) return COUNT_W'($urandom_range(1, 4));
      if (r < 95) return COUNT_W'($urandom_range(0, 255));
      return CUM_MAX;
   endfunction

   // Offer one count word and hold it until taken
   task automatic send_word(input logic [COUNT_W-1:0] count, input logic start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_code_count  <= count;
      req_table_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold the sender off until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   // Sender
   initial begin
      int sent;
      int table_kind;
      int noise_len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_LEN; i++)
         send_word(COUNT_W'(directed_counts[i]), directed_starts[i]);
      drain_results();

      // random tables: mostly well formed, some relying on the wrap, some noise
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         table_kind = $urandom_range(0, 99);
         quiet = ($urandom_range(0, 99) < 15);
         if (table_kind < 85) begin
            for (int i = 0; i < CODE_LENGTHS_DEF; i++)
               send_word(pick_count(), (i == 0) && (table_kind < 75));
            sent += CODE_LENGTHS_DEF;
         end else begin
            noise_len = $urandom_range(1, 20);
            for (int i = 0; i < noise_len; i++)
               send_word(COUNT_W'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            sent += noise_len;
         end
         if ($urandom_range(0, 99) < 3) drain_results();
      end
      quiet = 1'b0;

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Receiver: random stalls on the result side
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### files.f
rtl/hmtb_pkg.sv
rtl/hmtb_datapath.sv
rtl/huffman_mincode_table_builder_core.sv
tb/sv/huffman_mincode_table_builder_checker.sv
tb/sv/huffman_mincode_table_builder_core_tb.sv
